@@ src/run_length_stream_decoder_assert.svh @@
// assertion macros shared by the decoder modules
// expects clk_i and rst_ni in the including module
`ifndef RUN_LENGTH_STREAM_DECODER_ASSERT_SVH
`define RUN_LENGTH_STREAM_DECODER_ASSERT_SVH

// same-cycle property, disabled during reset
`define RLSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition implies a property in the next cycle
`define RLSD_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ src/rlsd_pkg.sv @@
// types and constants of the run-length stream decoder
// no dependencies
package rlsd_pkg;

  localparam int unsigned CountW = 6;

  localparam logic [7:0] END_MARK = 8'hFF;

  typedef enum logic [1:0] {
    MODE_COPY = 2'd0,
    MODE_INCR = 2'd1,
    MODE_BYTE = 2'd2,
    MODE_WORD = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_CONTROL,
    PH_COPY,
    PH_BYTEOP,
    PH_WORDLO,
    PH_WORDHI
  } phase_e;

  localparam logic [1:0] NBYTES_NONE = 2'd0;
  localparam logic [1:0] NBYTES_ONE  = 2'd1;
  localparam logic [1:0] NBYTES_TWO  = 2'd2;

  // one queued output command: data emitted reps times
  typedef struct packed {
    logic [15:0]       data;
    logic [1:0]        nbytes;
    logic [CountW-1:0] reps;
    logic              incr;
    logic              stream_end;
  } cmd_t;

endpackage

@@ src/rlsd_front.sv @@
// front end: parses header, control and operand bytes into commands
// depends on rlsd_pkg
module rlsd_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [7:0]     in_byte_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           q_full_i,
  output logic           push_o,
  output rlsd_pkg::cmd_t cmd_o
);

  rlsd_pkg::phase_e phase_q, phase_d;
  logic [rlsd_pkg::CountW-1:0] remaining_q, remaining_d;
  rlsd_pkg::mode_e mode_q, mode_d;
  logic [7:0] lo_q, lo_d;
  logic accept;
  logic gen;

  assign in_ready_o = !q_full_i;
  assign accept = in_valid_i && in_ready_o;
  assign push_o = accept && gen;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= rlsd_pkg::PH_HEADER;
      remaining_q <= '0;
      mode_q      <= rlsd_pkg::MODE_COPY;
      lo_q        <= '0;
    end else if (accept) begin
      phase_q     <= phase_d;
      remaining_q <= remaining_d;
      mode_q      <= mode_d;
      lo_q        <= lo_d;
    end
  end

  always_comb begin
    phase_d           = phase_q;
    remaining_d       = remaining_q;
    mode_d            = mode_q;
    lo_d              = lo_q;
    gen               = 1'b0;
    cmd_o.data        = {8'h00, in_byte_i};
    cmd_o.nbytes      = rlsd_pkg::NBYTES_ONE;
    cmd_o.reps        = rlsd_pkg::CountW'(1);
    cmd_o.incr        = 1'b0;
    cmd_o.stream_end  = 1'b0;
    unique case (phase_q)
      rlsd_pkg::PH_HEADER: begin
        phase_d = rlsd_pkg::PH_CONTROL;
      end
      rlsd_pkg::PH_CONTROL: begin
        if (in_byte_i == rlsd_pkg::END_MARK) begin
          gen              = 1'b1;
          cmd_o.data       = '0;
          cmd_o.nbytes     = rlsd_pkg::NBYTES_NONE;
          cmd_o.stream_end = 1'b1;
          phase_d          = rlsd_pkg::PH_HEADER;
        end else begin
          mode_d      = rlsd_pkg::mode_e'(in_byte_i[7:6]);
          remaining_d = in_byte_i[rlsd_pkg::CountW-1:0];
          unique case (rlsd_pkg::mode_e'(in_byte_i[7:6]))
            rlsd_pkg::MODE_COPY: begin
              phase_d = (in_byte_i[rlsd_pkg::CountW-1:0] != '0) ?
                        rlsd_pkg::PH_COPY : rlsd_pkg::PH_CONTROL;
            end
            rlsd_pkg::MODE_BYTE: phase_d = rlsd_pkg::PH_BYTEOP;
            default:             phase_d = rlsd_pkg::PH_WORDLO;
          endcase
        end
      end
      rlsd_pkg::PH_COPY: begin
        gen         = 1'b1;
        remaining_d = remaining_q - rlsd_pkg::CountW'(1);
        if (remaining_q == rlsd_pkg::CountW'(1)) begin
          phase_d = rlsd_pkg::PH_CONTROL;
        end
      end
      rlsd_pkg::PH_BYTEOP: begin
        gen         = (remaining_q != '0);
        cmd_o.reps  = remaining_q;
        remaining_d = '0;
        phase_d     = rlsd_pkg::PH_CONTROL;
      end
      rlsd_pkg::PH_WORDLO: begin
        lo_d    = in_byte_i;
        phase_d = rlsd_pkg::PH_WORDHI;
      end
      rlsd_pkg::PH_WORDHI: begin
        gen          = (remaining_q != '0);
        cmd_o.data   = {in_byte_i, lo_q};
        cmd_o.nbytes = rlsd_pkg::NBYTES_TWO;
        cmd_o.reps   = remaining_q;
        cmd_o.incr   = (mode_q == rlsd_pkg::MODE_INCR);
        remaining_d  = '0;
        phase_d      = rlsd_pkg::PH_CONTROL;
      end
      default: begin
        phase_d = rlsd_pkg::PH_HEADER;
      end
    endcase
  end

endmodule

@@ src/rlsd_fifo.sv @@
// command queue between front and back end
// depends on rlsd_pkg and the assertion macro header
`include "run_length_stream_decoder_assert.svh"
module rlsd_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rlsd_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output rlsd_pkg::cmd_t cmd_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  rlsd_pkg::cmd_t mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  `RLSD_ASSERT(a_no_push_full, !(push_i && full_o), "push into full queue")
  `RLSD_ASSERT(a_no_pop_empty, !(pop_i && !valid_o), "pop from empty queue")
  `RLSD_ASSERT_NEXT(a_ptr_count, push_i && !pop_i, count_q != '0, "count lost a push")

endmodule

@@ src/rlsd_back.sv @@
// back end: expands queued commands into result transactions
// depends on rlsd_pkg and the assertion macro header
`include "run_length_stream_decoder_assert.svh"
module rlsd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  rlsd_pkg::cmd_t cmd_i,
  output logic           pop_o,
  output logic [15:0]    out_data_o,
  output logic [1:0]     out_count_o,
  output logic           run_last_o,
  output logic           stream_end_o,
  output logic           out_valid_o,
  input  logic           out_ready_i
);

  logic                        valid_q;
  logic [15:0]                 data_q;
  logic [1:0]                  nbytes_q;
  logic [rlsd_pkg::CountW-1:0] reps_q;
  logic                        incr_q;
  logic                        end_q;
  logic advance, done;

  assign advance = valid_q && out_ready_i;
  assign done    = !valid_q || (advance && reps_q == rlsd_pkg::CountW'(1));
  assign pop_o   = done && q_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (done) begin
      valid_q <= q_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q   <= cmd_i.data;
      nbytes_q <= cmd_i.nbytes;
      reps_q   <= cmd_i.reps;
      incr_q   <= cmd_i.incr;
      end_q    <= cmd_i.stream_end;
    end else if (advance && !done) begin
      reps_q <= reps_q - rlsd_pkg::CountW'(1);
      data_q <= data_q + {15'd0, incr_q};
    end
  end

  assign out_valid_o  = valid_q;
  assign out_data_o   = data_q;
  assign out_count_o  = nbytes_q;
  assign run_last_o   = (reps_q == rlsd_pkg::CountW'(1));
  assign stream_end_o = end_q;

  `RLSD_ASSERT(a_reps_nonzero, !valid_q || reps_q != '0, "empty run in output stage")
  `RLSD_ASSERT(a_end_shape, !(valid_q && end_q) || (run_last_o && nbytes_q == '0),
               "malformed end transaction")
  `RLSD_ASSERT_NEXT(a_stall_hold, valid_q && !out_ready_i,
                    valid_q && $stable(data_q) && $stable(reps_q), "stalled output changed")

endmodule

@@ src/run_length_stream_decoder.sv @@
// a byte that completes a command is written into the command queue, then loaded into the output stage
// throughput: one input byte per cycle; a run of n results leaves as n output transactions,
//   and input stalls once the command queue is full while the back end drains a run
// the command queue depth sets how far the front end can run ahead of the back end
// reset: control state returns to expecting a header, queue and output stage empty
module run_length_stream_decoder #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  in_byte_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic [15:0] out_data_o,
  output logic [1:0]  out_count_o,
  output logic        run_last_o,
  output logic        stream_end_o,
  output logic        out_valid_o,
  input  logic        out_ready_i
);

  rlsd_pkg::cmd_t push_cmd, head_cmd;
  logic push, pop, q_full, q_valid;

  rlsd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_byte_i  (in_byte_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  rlsd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (head_cmd)
  );

  rlsd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .cmd_i        (head_cmd),
    .pop_o        (pop),
    .out_data_o   (out_data_o),
    .out_count_o  (out_count_o),
    .run_last_o   (run_last_o),
    .stream_end_o (stream_end_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i)
  );

endmodule

@@ tb/run_length_stream_decoder_checker.sv @@
// scoreboard for the run-length stream decoder: predicts results from the input channel
// and compares them with the output channel; depends on rlsd_pkg
`timescale 1ns / 100ps

module run_length_stream_decoder_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  in_byte_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [15:0] out_data_i,
  input  logic [1:0]  out_count_i,
  input  logic        run_last_i,
  input  logic        stream_end_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  output int          mismatch_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [15:0] data;
    logic [1:0]  nbytes;
    logic        last;
    logic        fin;
  } decoded_t;

  decoded_t                    expected_q[$];
  rlsd_pkg::phase_e            phase_q;
  rlsd_pkg::mode_e             mode_q;
  logic [rlsd_pkg::CountW-1:0] remaining_q;
  logic [7:0]                  low_byte_q;

  function automatic decoded_t result_of(logic [15:0] data, logic [1:0] nbytes,
                                         logic last, logic fin);
    decoded_t r;
    r.data   = data;
    r.nbytes = nbytes;
    r.last   = last;
    r.fin    = fin;
    return r;
  endfunction

  task automatic decode_byte(input logic [7:0] b);
    logic [15:0] word;
    int          i;
    case (phase_q)
      rlsd_pkg::PH_HEADER: begin
        phase_q = rlsd_pkg::PH_CONTROL;
      end
      rlsd_pkg::PH_CONTROL: begin
        if (b == rlsd_pkg::END_MARK) begin
          expected_q.push_back(result_of(16'h0000, rlsd_pkg::NBYTES_NONE, 1'b1, 1'b1));
          phase_q = rlsd_pkg::PH_HEADER;
        end else begin
          mode_q      = rlsd_pkg::mode_e'(b[7:6]);
          remaining_q = b[rlsd_pkg::CountW-1:0];
          case (mode_q)
            rlsd_pkg::MODE_COPY: begin
              phase_q = (remaining_q != '0) ? rlsd_pkg::PH_COPY : rlsd_pkg::PH_CONTROL;
            end
            rlsd_pkg::MODE_BYTE: phase_q = rlsd_pkg::PH_BYTEOP;
            default:             phase_q = rlsd_pkg::PH_WORDLO;
          endcase
        end
      end
      rlsd_pkg::PH_COPY: begin
        expected_q.push_back(result_of({8'h00, b}, rlsd_pkg::NBYTES_ONE, 1'b1, 1'b0));
        remaining_q = remaining_q - 1'b1;
        if (remaining_q == '0) phase_q = rlsd_pkg::PH_CONTROL;
      end
      rlsd_pkg::PH_BYTEOP: begin
        for (i = 0; i < int'(remaining_q); i++) begin
          expected_q.push_back(result_of({8'h00, b}, rlsd_pkg::NBYTES_ONE,
                                         i + 1 == int'(remaining_q), 1'b0));
        end
        remaining_q = '0;
        phase_q     = rlsd_pkg::PH_CONTROL;
      end
      rlsd_pkg::PH_WORDLO: begin
        low_byte_q = b;
        phase_q    = rlsd_pkg::PH_WORDHI;
      end
      rlsd_pkg::PH_WORDHI: begin
        word = {b, low_byte_q};
        for (i = 0; i < int'(remaining_q); i++) begin
          expected_q.push_back(result_of(word, rlsd_pkg::NBYTES_TWO,
                                         i + 1 == int'(remaining_q), 1'b0));
          if (mode_q == rlsd_pkg::MODE_INCR) word = word + 16'd1;
        end
        remaining_q = '0;
        phase_q     = rlsd_pkg::PH_CONTROL;
      end
      default: begin
        phase_q = rlsd_pkg::PH_HEADER;
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    decoded_t got;
    decoded_t want;
    if (!rst_ni) begin
      expected_q.delete();
      phase_q          = rlsd_pkg::PH_HEADER;
      mode_q           = rlsd_pkg::MODE_COPY;
      remaining_q      = '0;
      low_byte_q       = '0;
      mismatch_count_o <= 0;
      pending_o        <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = result_of(out_data_i, out_count_i, run_last_i, stream_end_i);
        if (expected_q.size() == 0) begin
          if (mismatch_count_o < 10) begin
            $display("unexpected transaction: data %h count %0d last %b end %b",
                     got.data, got.nbytes, got.last, got.fin);
          end
          mismatch_count_o <= mismatch_count_o + 1;
        end else begin
          want = expected_q.pop_front();
          if (got.data !== want.data || got.nbytes !== want.nbytes ||
              got.last !== want.last || got.fin !== want.fin) begin
            if (mismatch_count_o < 10) begin
              $display("mismatch: expected %h/%0d/%b/%b got %h/%0d/%b/%b",
                       want.data, want.nbytes, want.last, want.fin,
                       got.data, got.nbytes, got.last, got.fin);
            end
            mismatch_count_o <= mismatch_count_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) decode_byte(in_byte_i);
      pending_o <= expected_q.size();
    end
  end

endmodule

@@ tb/run_length_stream_decoder_tb.sv @@
// top of the run-length stream decoder testbench: clock, reset, byte streams and output stalls
// depends on rlsd_pkg, run_length_stream_decoder and run_length_stream_decoder_checker
`timescale 1ns / 100ps

module run_length_stream_decoder_tb;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int RANDOM_BYTES = 175;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam logic [rlsd_pkg::CountW-1:0] MAX_COUNT = '1;

  localparam logic [7:0] DIRECTED_BYTES [26] = '{
    8'h00,
    {rlsd_pkg::MODE_COPY, 6'd0},
    {rlsd_pkg::MODE_COPY, 6'd2}, 8'h00, 8'hFF,
    {rlsd_pkg::MODE_INCR, 6'd3}, 8'hFE, 8'hFF,
    {rlsd_pkg::MODE_BYTE, 6'd0}, 8'h55,
    {rlsd_pkg::MODE_BYTE, 6'd3}, 8'hFF,
    {rlsd_pkg::MODE_WORD, 6'd62}, 8'h34, 8'h12,
    {rlsd_pkg::MODE_INCR, 6'd0}, 8'hA5, 8'h5A,
    rlsd_pkg::END_MARK,
    8'hFF,
    {rlsd_pkg::MODE_BYTE, 6'd63}, 8'hAA,
    {rlsd_pkg::MODE_WORD, 6'd0}, 8'h01, 8'h80,
    rlsd_pkg::END_MARK
  };

  logic        clk;
  logic        rst_n;
  logic [7:0]  in_byte;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] out_data;
  logic [1:0]  out_count;
  logic        run_last;
  logic        stream_end;
  logic        out_valid;
  logic        out_ready;
  int          mismatch_count;
  int          pending;
  int          cycle_count;
  int          random_sent;
  bit          send_idle;
  bit          recv_idle;
  bit          hold_request;

  run_length_stream_decoder DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_byte_i    (in_byte),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .out_data_o   (out_data),
    .out_count_o  (out_count),
    .run_last_o   (run_last),
    .stream_end_o (stream_end),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready)
  );

  run_length_stream_decoder_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_byte_i        (in_byte),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .out_data_i       (out_data),
    .out_count_i      (out_count),
    .run_last_i       (run_last),
    .stream_end_i     (stream_end),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = send_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random_stream();
    int                          ncmd;
    int                          pick;
    rlsd_pkg::mode_e             mode;
    logic [rlsd_pkg::CountW-1:0] count;
    send_idle = ($urandom_range(0, 3) != 0);
    recv_idle = ($urandom_range(0, 3) != 0);
    send_byte(8'($urandom_range(0, 255)));
    random_sent++;
    ncmd = $urandom_range(1, 6);
    repeat (ncmd) begin
      if ($urandom_range(0, 9) == 0) begin
        send_byte(8'($urandom_range(0, 255)));
        random_sent++;
      end
      mode  = rlsd_pkg::mode_e'($urandom_range(0, 3));
      pick  = $urandom_range(0, 9);
      count = (pick < 6) ? rlsd_pkg::CountW'($urandom_range(0, 4)) :
              (pick < 9) ? rlsd_pkg::CountW'($urandom_range(5, 15)) :
                           rlsd_pkg::CountW'($urandom_range(16, 63));
      if (mode == rlsd_pkg::MODE_WORD && count == MAX_COUNT) count = MAX_COUNT - 1'b1;
      send_byte({mode, count});
      random_sent++;
      case (mode)
        rlsd_pkg::MODE_COPY: begin
          repeat (count) begin
            send_byte(8'($urandom_range(0, 255)));
            random_sent++;
          end
        end
        rlsd_pkg::MODE_BYTE: begin
          send_byte(8'($urandom_range(0, 255)));
          random_sent++;
        end
        default: begin
          repeat (2) begin
            send_byte(8'($urandom_range(0, 255)));
            random_sent++;
          end
        end
      endcase
    end
    if ($urandom_range(0, 7) != 0) begin
      send_byte(rlsd_pkg::END_MARK);
      random_sent++;
    end
  endtask

  // receiver side: per-transaction stalls plus one long hold-off
  initial begin
    int stall;
    out_ready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        stall = recv_idle ? $urandom_range(0, 9) : 0;
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("run_length_stream_decoder_tb: FAIL");
    $finish;
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_byte      = 8'h00;
    send_idle    = 1'b1;
    recv_idle    = 1'b1;
    hold_request = 1'b0;
    random_sent  = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED_BYTES[i]) send_byte(DIRECTED_BYTES[i]);

    // let the output side drain completely before random traffic
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);

    hold_request = 1'b1;
    while (random_sent < RANDOM_BYTES) send_random_stream();

    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending == 0) begin
      $display("run_length_stream_decoder_tb: PASS");
    end else begin
      $display("run_length_stream_decoder_tb: FAIL");
    end
    $finish;
  end

endmodule
